FILE: rtl/core/f32a_pkg.sv
// ----------------------------------------------------------------------------
// f32a_pkg: shared types and constants for the float32 adder
// Operand unpack constants, stage payload structs, and a leading-count helper.
// ----------------------------------------------------------------------------
package f32a_pkg;

  localparam logic [31:0] FRAC_MASK  = 32'h3FFF_FF80;
  localparam logic [31:0] HIDDEN_ONE = 32'h4000_0000;
  localparam logic [7:0]  EXP_BIAS   = 8'd127;
  localparam logic [4:0]  MAX_ALIGN  = 5'd31;

  // aligned operands, ready for the add
  typedef struct packed {
    logic [31:0]       big_frac;
    logic [31:0]       small_frac;
    logic [4:0]        shamt;
    logic signed [8:0] exp;
  } align_t;

  // raw sum, ready for normalization
  typedef struct packed {
    logic [31:0]       sum;
    logic signed [8:0] exp;
  } sum_t;

  // sum plus its normalize distance
  typedef struct packed {
    logic [31:0]       sum;
    logic signed [8:0] exp;
    logic [4:0]        lead;
  } lead_t;

  // leading bits below bit 31 equal to the sign, from bit 30 down; 0 for zero
  function automatic logic [4:0] lead_count(input logic [31:0] v);
    logic [30:0] x;
    logic [4:0]  n;
    x = v[30:0] ^ {31{v[31]}};
    n = 5'd31;
    for (int i = 0; i < 31; i++) begin
      if (x[i]) n = 5'(30 - i);
    end
    if (v == 32'd0) n = 5'd0;
    return n;
  endfunction

endpackage

FILE: rtl/core/float32_add_to_internal.sv
// Four register stages, the last one driving the output. Throughput: one beat
// per cycle while the output is not stalled.
// Stages: unpack/compare, align/add, leading count, normalize shift.
// A stalled output freezes every stage; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all stage valid bits.
// ----------------------------------------------------------------------------
// float32_add_to_internal: pipelined float32 add to internal fraction/exponent
// Sums two single-precision patterns into a normalized two's-complement form.
// ----------------------------------------------------------------------------
module float32_add_to_internal (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // a_bits[31:0], b_bits[63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // sum_fraction[31:0], sum_exponent[40:32], zero pad
);

  logic en;
  logic v1_r, v2_r, v3_r, v4_r;
  f32a_pkg::align_t s1_nxt, s1_r;
  f32a_pkg::sum_t   s2_nxt, s2_r;
  f32a_pkg::lead_t  s3_nxt, s3_r;
  logic [31:0]       frac_nxt, frac_r;
  logic signed [8:0] exp_nxt, exp_r;

  assign en        = ~v4_r | out_tready;
  assign in_tready = en;

  f32a_unpack u_unpack (
    .a_bits (in_tdata[31:0]),
    .b_bits (in_tdata[63:32]),
    .op     (s1_nxt)
  );

  f32a_align u_align (
    .op  (s1_r),
    .res (s2_nxt)
  );

  always_comb begin
    s3_nxt.sum  = s2_r.sum;
    s3_nxt.exp  = s2_r.exp;
    s3_nxt.lead = f32a_pkg::lead_count(s2_r.sum);
  end

  f32a_norm u_norm (
    .op   (s3_r),
    .frac (frac_nxt),
    .exp  (exp_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      s3_r   <= s3_nxt;
      frac_r <= frac_nxt;
      exp_r  <= exp_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {7'd0, exp_r, frac_r};

endmodule

FILE: rtl/core/f32a_unpack.sv
// ----------------------------------------------------------------------------
// f32a_unpack: operand unpack and exponent compare stage
// Forms signed fractions, picks the larger exponent and the align distance.
// ----------------------------------------------------------------------------
module f32a_unpack (
  input  logic [31:0]      a_bits,
  input  logic [31:0]      b_bits,
  output f32a_pkg::align_t op
);

  logic [31:0]       fa, fb, fa_raw, fb_raw;
  logic signed [8:0] ea, eb;
  logic signed [9:0] diff;
  logic [9:0]        mag;

  always_comb begin
    fa_raw = ((a_bits << 7) & f32a_pkg::FRAC_MASK) | f32a_pkg::HIDDEN_ONE;
    fb_raw = ((b_bits << 7) & f32a_pkg::FRAC_MASK) | f32a_pkg::HIDDEN_ONE;
    fa = a_bits[31] ? (~fa_raw + 32'd1) : fa_raw;
    fb = b_bits[31] ? (~fb_raw + 32'd1) : fb_raw;
    ea = $signed({1'b0, a_bits[30:23]}) - $signed({1'b0, f32a_pkg::EXP_BIAS});
    eb = $signed({1'b0, b_bits[30:23]}) - $signed({1'b0, f32a_pkg::EXP_BIAS});
    diff = {ea[8], ea} - {eb[8], eb};
    mag = diff[9] ? (~diff + 10'd1) : diff;
    op.shamt = (mag > 10'd31) ? f32a_pkg::MAX_ALIGN : mag[4:0];
    if (diff[9]) begin
      op.big_frac   = fb;
      op.small_frac = fa;
      op.exp        = eb + 9'sd1;
    end else begin
      op.big_frac   = fa;
      op.small_frac = fb;
      op.exp        = ea + 9'sd1;
    end
  end

endmodule

FILE: rtl/core/f32a_align.sv
// ----------------------------------------------------------------------------
// f32a_align: alignment shift and halved add stage
// Shifts the smaller operand right, halves both and sums them.
// ----------------------------------------------------------------------------
module f32a_align (
  input  f32a_pkg::align_t op,
  output f32a_pkg::sum_t   res
);

  logic signed [31:0] small_al;

  always_comb begin
    small_al = $signed(op.small_frac) >>> op.shamt;
    res.sum  = 32'($signed(op.big_frac) >>> 1) + 32'(small_al >>> 1);
    res.exp  = op.exp;
  end

endmodule

FILE: rtl/core/f32a_norm.sv
// ----------------------------------------------------------------------------
// f32a_norm: normalize shift stage
// Left shifts the sum by the precomputed count and adjusts the exponent.
// ----------------------------------------------------------------------------
module f32a_norm (
  input  f32a_pkg::lead_t   op,
  output logic [31:0]       frac,
  output logic signed [8:0] exp
);

  always_comb begin
    frac = op.sum << op.lead;
    exp  = op.exp - $signed({4'd0, op.lead});
  end

endmodule

FILE: dv/float32_add_to_internal_tb.sv
// ----------------------------------------------------------------------------
// float32_add_to_internal_tb: self-checking bench for the float32 adder
// Drives operand pairs over the input stream with random gaps, predicts the
// normalized fraction/exponent of each sum, and checks every output beat in
// order, with random and long output stalls.
// ----------------------------------------------------------------------------
module float32_add_to_internal_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int SHOW_MAX    = 10;

  typedef struct packed {
    logic signed [31:0] frac;
    logic signed [8:0]  exp;
  } sum_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;     // a_bits[31:0], b_bits[63:32]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // sum_fraction[31:0], sum_exponent[40:32], pad

  sum_res_t pending_sums[$];
  int       mismatches = 0;
  int       beats_checked = 0;
  int       pairs_sent = 0;
  int       cycles = 0;
  bit       gaps_on = 1'b0;
  bit       hold_req = 1'b0;

  float32_add_to_internal DUT (.*);

  always #4 clk = ~clk;

  // --- predictor ------------------------------------------------------------
  function automatic logic [31:0] asr_sat(logic [31:0] v, int n);
    if (n > 31) n = 31;
    return $unsigned($signed(v) >>> n);
  endfunction

  function automatic sum_res_t float_sum(logic [31:0] a, logic [31:0] b);
    logic [31:0] fa, fb, s, sg;
    int          ea, eb, e;
    sum_res_t    r;
    fa = ((a << 7) & 32'h3FFF_FF80) | 32'h4000_0000;
    fb = ((b << 7) & 32'h3FFF_FF80) | 32'h4000_0000;
    if (a[31]) fa = -fa;
    if (b[31]) fb = -fb;
    ea = int'(a[30:23]) - 127;
    eb = int'(b[30:23]) - 127;
    if (ea > eb) begin
      fb = asr_sat(fb, ea - eb);
      e = ea;
    end else begin
      fa = asr_sat(fa, eb - ea);
      e = eb;
    end
    s = asr_sat(fa, 1) + asr_sat(fb, 1);
    e = e + 1;
    if (s != 0) begin
      sg = (s >> 1) & 32'h4000_0000;
      for (int i = 0; i < 32; i++) begin
        if (((s ^ sg) & 32'h4000_0000) != 0) break;
        s = s << 1;
        e = e - 1;
      end
    end
    r.frac = s;
    r.exp = e[8:0];
    return r;
  endfunction

  // --- driving --------------------------------------------------------------
  task automatic send_pair(logic [31:0] a, logic [31:0] b);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    do @(posedge clk); while (!in_tready);
    pending_sums.push_back(float_sum(a, b));
    pairs_sent++;
    if (gaps_on && $urandom_range(3) == 0) begin
      gap = $urandom_range(15, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // output side: random stalls, plus one long hold on request
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(4) == 0) begin
        n = $urandom_range(15, 1);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // --- checking -------------------------------------------------------------
  always @(posedge clk) begin
    sum_res_t want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX) $display("unexpected beat %h", out_tdata);
      end else begin
        want = pending_sums.pop_front();
        beats_checked++;
        if (out_tdata[31:0] !== want.frac || out_tdata[40:32] !== want.exp) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("mismatch: exp frac %h e %0d, got frac %h e %0d",
                     want.frac, want.exp, out_tdata[31:0], $signed(out_tdata[40:32]));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("float32_add_to_internal_tb: FAIL");
      $finish;
    end
  end

  // --- tests ----------------------------------------------------------------
  task automatic test_directed();
    send_pair(32'h0000_0000, 32'h0000_0000);   // zeros still get the hidden one
    send_pair(32'h8000_0000, 32'h0000_0000);   // opposite signs cancel to zero
    send_pair(32'h3F80_0000, 32'hBF80_0000);
    send_pair(32'h7F80_0000, 32'hFF80_0000);   // infinities
    send_pair(32'h7FC0_0000, 32'h3F80_0000);   // nan pattern
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h0000_0001, 32'h807F_FFFF);   // denormals
    send_pair(32'h7F7F_FFFF, 32'h0000_0000);   // huge exponent gap, saturated
    send_pair(32'h0000_0000, 32'hFF7F_FFFF);
    send_pair(32'h4F80_0000, 32'h3F80_0000);   // gap of exactly 32
    send_pair(32'h4F00_0000, 32'hBF80_0000);   // gap of exactly 31
    send_pair(32'h4E80_0000, 32'hBF80_0000);   // gap of 30
    send_pair(32'h3FFF_FFFF, 32'hBFFF_FF80);   // deep cancellation
    send_pair(32'h3F80_0001, 32'hBF80_0000);
    send_pair(32'hC000_0000, 32'h3FFF_FFFF);
    send_pair(32'h4040_0000, 32'h4040_0000);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555);
    send_pair(32'h5555_5555, 32'hAAAA_AAAA);
    send_pair(32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  task automatic test_random(int count);
    logic [31:0] a, b;
    for (int i = 0; i < count; i++) begin
      a = $urandom;
      case ($urandom_range(3))
        0: b = $urandom;
        1: begin // nearby exponent, random sign and fraction
          b = $urandom;
          b[30:23] = a[30:23] + 8'($urandom_range(6)) - 8'd3;
        end
        2: begin // near cancellation
          b = a ^ 32'h8000_0000;
          b[7:0] = $urandom;
        end
        default: begin // wide gaps around 31
          b = $urandom;
          b[30:23] = a[30:23] + 8'($urandom_range(40, 24));
        end
      endcase
      send_pair(a, b);
    end
  endtask

  task automatic test_backpressure(int count);
    hold_req = 1'b1;
    repeat (count) send_pair($urandom, $urandom);
  endtask

  task automatic wait_drained();
    while (pending_sums.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gaps_on = 1'b1;
    test_directed();
    test_random(920);
    test_backpressure(60);
    gaps_on = 1'b0;
    test_random(150);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    $display("sent %0d operand pairs, checked %0d sums (specials, cancellation,",
             pairs_sent, beats_checked);
    $display("saturated alignment, random stalls and a long output hold)");
    if (mismatches == 0 && pending_sums.size() == 0) begin
      $display("float32_add_to_internal_tb: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("float32_add_to_internal_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/f32a_pkg.sv
rtl/core/f32a_unpack.sv
rtl/core/f32a_align.sv
rtl/core/f32a_norm.sv
rtl/core/float32_add_to_internal.sv
dv/float32_add_to_internal_tb.sv
